>>> sv/xrg_pkg.sv
// shared constants, types and the xorshift step for the range generator
`timescale 1ns / 1ps

package xrg_pkg;

    localparam int unsigned STATE_W = 64;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CNT_W   = $clog2(WORD_W);

    localparam int unsigned SHIFT_A = 13;
    localparam int unsigned SHIFT_B = 7;
    localparam int unsigned SHIFT_C = 17;

    // status of the bit-serial remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // one xorshift step: left 13, right 7, left 17
    function automatic logic [STATE_W-1:0] xs_advance(input logic [STATE_W-1:0] x);
        logic [STATE_W-1:0] a;
        logic [STATE_W-1:0] b;
        a = x ^ (x << SHIFT_A);
        b = a ^ (a >> SHIFT_B);
        return b ^ (b << SHIFT_C);
    endfunction

endpackage

>>> sv/xrg_xorshift.sv
// generator state register with seed load and single-step advance
`timescale 1ns / 1ps

module xrg_xorshift
    import xrg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_seed_we,
    input  logic [WORD_W-1:0]  i_seed_value,
    input  logic               i_step,
    output logic [STATE_W-1:0] o_state,
    output logic [STATE_W-1:0] o_next
);

    logic [STATE_W-1:0] r_state;
    logic [STATE_W-1:0] n_state;

    assign o_next  = xs_advance(r_state);
    assign o_state = r_state;

    always_comb begin
        n_state = r_state;
        if (i_seed_we) begin
            // zero seed loads as one
            if (i_seed_value == '0) begin
                n_state = STATE_W'(1);
            end else begin
                n_state = {{(STATE_W-WORD_W){1'b0}}, i_seed_value};
            end
        end else if (i_step) begin
            n_state = o_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_W'(1);
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/xrg_mod_serial.sv
// restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module xrg_mod_serial
    import xrg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_dividend,
    input  logic [WORD_W-1:0] i_divisor,
    output t_div_stat         o_stat,
    output logic [WORD_W-1:0] o_rem
);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_dvd;
    logic [WORD_W-1:0] r_div;
    logic [WORD_W-1:0] r_rem;

    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   trial;

    // bring in the next dividend bit and try a subtract
    assign shifted = {r_rem, r_dvd[WORD_W-1]};
    assign trial   = shifted - {1'b0, r_div};

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && (r_cnt == CNT_W'(WORD_W-1));
    assign o_rem       = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (o_stat.done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // partial remainder stays below the divisor, so it fits in one word
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
            if (trial[WORD_W]) begin
                r_rem <= shifted[WORD_W-1:0];
            end else begin
                r_rem <= trial[WORD_W-1:0];
            end
        end
    end

endmodule

>>> sv/xorshift64_range_generator.sv
// top level of the xorshift64 bounded random number generator
`timescale 1ns / 1ps

// usage:
//  - request channel: i_in_valid / o_in_stall with i_range_low and i_range_high;
//    a transfer happens on a rising edge with valid high and stall low
//  - result channel: o_out_valid / i_out_stall with o_ranged_value and o_raw_value
//  - seed: pulse i_seed_we with i_seed_value while idle; zero loads as one
//  - nonempty span (low < high): the state steps once at the request transfer,
//    then the bit-serial remainder unit works through the dividend a bit at
//    a time, and the finish state adds low and loads the result register
//  - empty span: the result holds low and the unchanged state
//  - one request in flight; a new request is taken only in the idle state
//  - the result register parts the channels: a request can be taken and
//    worked on while an earlier result waits under stall; a finished result
//    waits in the finish state until the result register frees up
//  - reset (synchronous, active low): state becomes one, no result pending

module xorshift64_range_generator
    import xrg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_seed_we,
    input  logic [WORD_W-1:0]  i_seed_value,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [WORD_W-1:0]  i_range_low,
    input  logic [WORD_W-1:0]  i_range_high,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [WORD_W-1:0]  o_ranged_value,
    output logic [STATE_W-1:0] o_raw_value
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state             r_state;
    logic               r_empty;
    logic [WORD_W-1:0]  r_low;
    logic [WORD_W-1:0]  r_span;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_ranged;
    logic [STATE_W-1:0] r_raw;

    logic               in_xfer;
    logic               out_free;
    logic [WORD_W:0]    span_ext;
    logic               span_ok;
    logic               step;
    logic [STATE_W-1:0] gen_state;
    logic [STATE_W-1:0] gen_next;
    t_div_stat          div_stat;
    logic [WORD_W-1:0]  div_rem;
    logic [WORD_W-1:0]  addend;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    // the result register can take a new value when empty or being drained
    assign out_free   = !r_out_valid || !i_out_stall;

    // a borrow or a zero difference of high - low tells an empty span
    assign span_ext = {1'b0, i_range_high} - {1'b0, i_range_low};
    assign span_ok  = !span_ext[WORD_W] && (span_ext[WORD_W-1:0] != '0);
    assign step     = in_xfer && span_ok;

    xrg_xorshift u_gen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_we    (i_seed_we),
        .i_seed_value (i_seed_value),
        .i_step       (step),
        .o_state      (gen_state),
        .o_next       (gen_next)
    );

    // remainder of the advanced state's low word by the span
    xrg_mod_serial u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (step),
        .i_dividend (gen_next[WORD_W-1:0]),
        .i_divisor  (span_ext[WORD_W-1:0]),
        .o_stat     (div_stat),
        .o_rem      (div_rem)
    );

    // low + remainder never wraps since remainder < high - low
    assign addend = r_empty ? '0 : div_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // in the finish state the result register is handled below
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state <= span_ok ? S_DIV : S_DONE;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_low   <= i_range_low;
            r_span  <= span_ext[WORD_W-1:0];
            r_empty <= !span_ok;
        end
        if (r_state == S_DONE && out_free) begin
            r_ranged <= r_low + addend;
            r_raw    <= gen_state;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_ranged_value = r_ranged;
    assign o_raw_value    = r_raw;

    // remainder unit only finishes while the sequencer waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("remainder done outside divide state");

    // a nonempty request starts the remainder unit
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> div_stat.busy)
        else $error("remainder unit not started");

    // the finished remainder is below the span
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_empty) |-> (div_rem < r_span))
        else $error("remainder not below span");

    // the generator state never reaches zero
    a_raw_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_raw_value != '0))
        else $error("raw value is zero");

endmodule
